// ===== rtl/spcr_pkg.sv =====
// Shared types, constants and helpers for the sphere pair collision core.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package spcr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam logic [30:0] CONTACT_DIST_RST = 31'd131203;

    // shared divider: widest dividend is depth * |d|, widest divisor is m1 + m2
    localparam int DIV_NUM_W = 62;
    localparam int DIV_DEN_W = 33;

    // scaled dot product and impulse weights
    localparam int S_W = 37;
    localparam int W_W = 39;

    localparam logic [1:0] LAST_AXIS = 2'd2;

    typedef enum logic [1:0] {
        ST_NO_CONTACT = 2'd0,
        ST_RESOLVED   = 2'd1,
        ST_COINCIDENT = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CAPTURE,
        OP_SQ,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_PREP,
        OP_DIV_START,
        OP_DIV_STORE,
        OP_DOT,
        OP_SCALE,
        OP_W1,
        OP_W2,
        OP_VEL1,
        OP_VEL2,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        JOB_N0,
        JOB_N1,
        JOB_N2,
        JOB_P0,
        JOB_P1,
        JOB_P2,
        JOB_R1,
        JOB_R2
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SQ,
        S_CMP,
        S_SQRT,
        S_PREP,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DOT,
        S_SCALE,
        S_W1,
        S_W2,
        S_VEL1,
        S_VEL2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [31:0]      mass;
    } t_body;

    typedef struct packed {
        t_status          status;
        logic [2:0][31:0] pos1;
        logic [2:0][31:0] vel1;
        logic [2:0][31:0] vel2;
    } t_result;

    typedef struct packed {
        t_op        op;
        logic [1:0] idx;
        t_job       job;
        t_status    status;
    } t_cmd;

    typedef struct packed {
        logic have_first;
        logic zero;
        logic far;
        logic sq_over;
        logic sqrt_last;
        logic div_done;
    } t_flags;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/spcr_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on spcr_pkg for default widths.
`default_nettype none

module spcr_div
    import spcr_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] rem_sub;
    logic           fits;

    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        fits    = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // dividend shifts out of the top of r_quo as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// ===== rtl/spcr_datapath.sv =====
// Datapath: body store, contact test, square root, impulse arithmetic, result register.
// Depends on spcr_pkg and spcr_div.
`default_nettype none

module spcr_datapath
    import spcr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire t_body       i_body,
    input  wire logic        i_cfg_we,
    input  wire logic [30:0] i_cfg_data,
    output t_flags           o_flags,
    output logic             o_strobe,
    output t_result          o_result
);

    localparam int NW    = FRAC_BITS + 2;
    localparam int RW    = FRAC_BITS + 1;
    localparam int DP_W  = 33 + NW;
    localparam int DOT_W = S_W + FRAC_BITS;
    localparam int WP_W  = S_W + RW + 2;
    localparam int VP_W  = W_W + NW;
    localparam int DL_W  = W_W + 2;

    logic signed [31:0]    r_p1 [3];
    logic signed [31:0]    r_v1 [3];
    logic [31:0]           r_m1;
    logic                  r_have_first;
    logic [30:0]           r_cdist;
    logic                  r_strobe;

    logic signed [31:0]    r_v2 [3];
    logic [31:0]           r_m2;
    logic signed [32:0]    r_d [3];
    logic [61:0]           r_cc;
    logic [63:0]           r_sq;
    logic [61:0]           r_sx;
    logic [61:0]           r_sr;
    logic [60:0]           r_sb;
    logic [30:0]           r_dist;
    logic [30:0]           r_depth;
    logic [32:0]           r_msum;
    logic signed [NW-1:0]  r_n [3];
    logic signed [31:0]    r_np1 [3];
    logic [RW-1:0]         r_r1;
    logic [RW-1:0]         r_r2;
    logic signed [DOT_W-1:0] r_dot;
    logic signed [S_W-1:0] r_s;
    logic signed [W_W-1:0] r_w1;
    logic signed [W_W-1:0] r_w2;
    logic signed [31:0]    r_nv1 [3];
    logic signed [31:0]    r_nv2 [3];
    t_result               r_result;

    logic [32:0]             d_mag [3];
    logic signed [32:0]      d_new [3];
    logic                    zero;
    logic                    far;
    logic [30:0]             sq_mag;
    logic [61:0]             sq_prod;
    logic [62:0]             sq_t;
    logic                    sq_ge;
    logic [30:0]             dist_fix;
    logic [31:0]             m1f;
    logic [31:0]             m2f;
    logic [1:0]              job_axis;
    logic [30:0]             job_mag;
    logic                    job_neg;
    logic [61:0]             push_prod;
    logic [DIV_NUM_W-1:0]    div_num;
    logic [DIV_DEN_W-1:0]    div_den;
    logic                    div_start;
    logic                    div_done;
    logic [DIV_NUM_W-1:0]    quot;
    logic signed [NW-1:0]    n_mag;
    logic signed [NW-1:0]    n_val;
    logic signed [32:0]      push_s;
    logic signed [63:0]      np1_wide;
    logic signed [32:0]      vdiff;
    logic signed [DP_W-1:0]  dprod;
    logic signed [DOT_W-1:0] dot_bias;
    logic signed [DOT_W-1:0] dot_shift;
    logic [RW-1:0]           w_r;
    logic signed [WP_W-1:0]  wprod;
    logic signed [WP_W-1:0]  w_bias;
    logic signed [WP_W-1:0]  w_shift;
    logic signed [W_W-1:0]   w_sel;
    logic signed [VP_W-1:0]  vprod;
    logic signed [VP_W-1:0]  v_bias;
    logic signed [VP_W-1:0]  v_shift;
    logic signed [DL_W-1:0]  delta;
    logic signed [31:0]      vel_base;
    logic signed [63:0]      vsum;

    always_comb begin
        zero = 1'b1;
        far  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            d_mag[i] = r_d[i][32] ? 33'(-r_d[i]) : 33'(r_d[i]);
            d_new[i] = 33'(signed'(i_body.pos[i])) - 33'(r_p1[i]);
            if (r_d[i] != '0) begin
                zero = 1'b0;
            end
            if (d_mag[i] > {2'b00, r_cdist}) begin
                far = 1'b1;
            end
        end
    end

    always_comb begin
        sq_mag  = d_mag[i_cmd.idx][30:0];
        sq_prod = sq_mag * sq_mag;
        sq_t    = {1'b0, r_sr} + {2'b00, r_sb};
        sq_ge   = {1'b0, r_sx} >= sq_t;
        dist_fix = (r_sr[30:0] == '0) ? 31'd1 : r_sr[30:0];
        m1f = (r_m1 == '0) ? 32'd1 : r_m1;
        m2f = (r_m2 == '0) ? 32'd1 : r_m2;
    end

    always_comb begin
        case (i_cmd.job)
            JOB_N0, JOB_P0: job_axis = 2'd0;
            JOB_N1, JOB_P1: job_axis = 2'd1;
            JOB_N2, JOB_P2: job_axis = 2'd2;
            default:        job_axis = 2'd0;
        endcase
        job_mag   = d_mag[job_axis][30:0];
        job_neg   = r_d[job_axis][32];
        push_prod = r_depth * job_mag;
        case (i_cmd.job)
            JOB_N0, JOB_N1, JOB_N2: begin
                div_num = DIV_NUM_W'(job_mag) << FRAC_BITS;
                div_den = DIV_DEN_W'(r_dist);
            end
            JOB_P0, JOB_P1, JOB_P2: begin
                div_num = DIV_NUM_W'(push_prod);
                div_den = DIV_DEN_W'(r_dist);
            end
            JOB_R1: begin
                div_num = DIV_NUM_W'(m1f) << FRAC_BITS;
                div_den = r_msum;
            end
            default: begin
                div_num = DIV_NUM_W'(m2f) << FRAC_BITS;
                div_den = r_msum;
            end
        endcase
        div_start = (i_cmd.op == OP_DIV_START);
    end

    spcr_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // quotients come back as magnitudes: restore the sign of d
    always_comb begin
        n_mag    = $signed({1'b0, quot[FRAC_BITS:0]});
        n_val    = job_neg ? -n_mag : n_mag;
        push_s   = job_neg ? -$signed({2'b00, quot[30:0]}) : $signed({2'b00, quot[30:0]});
        np1_wide = 64'(r_p1[job_axis]) - 64'(push_s);
    end

    // divisions by 2^F truncate toward zero: add 2^F-1 to negatives first
    always_comb begin
        vdiff     = 33'(r_v2[i_cmd.idx]) - 33'(r_v1[i_cmd.idx]);
        dprod     = vdiff * r_n[i_cmd.idx];
        dot_bias  = r_dot + $signed(DOT_W'({FRAC_BITS{r_dot[DOT_W-1]}}));
        dot_shift = dot_bias >>> FRAC_BITS;

        w_r     = (i_cmd.op == OP_W1) ? r_r2 : r_r1;
        wprod   = $signed({r_s, 1'b0}) * $signed({1'b0, w_r});
        w_bias  = wprod + $signed(WP_W'({FRAC_BITS{wprod[WP_W-1]}}));
        w_shift = w_bias >>> FRAC_BITS;

        w_sel   = (i_cmd.op == OP_VEL1) ? r_w1 : r_w2;
        vprod   = w_sel * r_n[i_cmd.idx];
        v_bias  = vprod + $signed(VP_W'({FRAC_BITS{vprod[VP_W-1]}}));
        v_shift = v_bias >>> FRAC_BITS;
        delta   = v_shift[DL_W-1:0];

        if (i_cmd.op == OP_VEL1) begin
            vel_base = r_v1[i_cmd.idx];
            vsum     = 64'(vel_base) + 64'(delta);
        end else begin
            vel_base = r_v2[i_cmd.idx];
            vsum     = 64'(vel_base) - 64'(delta);
        end
    end

    // first body, configuration and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_p1[i] <= '0;
                r_v1[i] <= '0;
            end
            r_m1         <= '0;
            r_have_first <= 1'b0;
            r_cdist      <= CONTACT_DIST_RST;
            r_strobe     <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.op == OP_OUT);
            if (i_cfg_we) begin
                r_cdist <= i_cfg_data;
            end
            if (i_cmd.op == OP_LOAD) begin
                for (int i = 0; i < 3; i++) begin
                    r_p1[i] <= i_body.pos[i];
                    r_v1[i] <= i_body.vel[i];
                end
                r_m1         <= i_body.mass;
                r_have_first <= 1'b1;
            end else if (i_cmd.op == OP_OUT && i_cmd.status == ST_RESOLVED) begin
                for (int i = 0; i < 3; i++) begin
                    r_p1[i] <= r_np1[i];
                    r_v1[i] <= r_nv1[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                for (int i = 0; i < 3; i++) begin
                    r_v2[i] <= i_body.vel[i];
                    r_d[i]  <= d_new[i];
                end
                r_m2 <= i_body.mass;
                r_cc <= r_cdist * r_cdist;
                r_sq <= '0;
            end
            OP_SQ: begin
                r_sq <= r_sq + 64'(sq_prod);
            end
            OP_SQRT_INIT: begin
                r_sx <= r_sq[61:0];
                r_sr <= '0;
                r_sb <= {1'b1, 60'd0};
            end
            OP_SQRT_STEP: begin
                if (sq_ge) begin
                    r_sx <= r_sx - sq_t[61:0];
                    r_sr <= (r_sr >> 1) + 62'(r_sb);
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sb <= r_sb >> 2;
            end
            OP_PREP: begin
                r_dist  <= dist_fix;
                r_depth <= r_cdist - dist_fix;
                r_msum  <= 33'(m1f) + 33'(m2f);
                r_dot   <= '0;
            end
            OP_DIV_STORE: begin
                case (i_cmd.job)
                    JOB_N0, JOB_N1, JOB_N2: r_n[job_axis] <= n_val;
                    JOB_P0, JOB_P1, JOB_P2: r_np1[job_axis] <= sat32(np1_wide);
                    JOB_R1: r_r1 <= quot[RW-1:0];
                    default: r_r2 <= quot[RW-1:0];
                endcase
            end
            OP_DOT: begin
                r_dot <= r_dot + DOT_W'(dprod);
            end
            OP_SCALE: begin
                r_s <= dot_shift[S_W-1:0];
            end
            OP_W1: begin
                r_w1 <= w_shift[W_W-1:0];
            end
            OP_W2: begin
                r_w2 <= w_shift[W_W-1:0];
            end
            OP_VEL1: begin
                r_nv1[i_cmd.idx] <= sat32(vsum);
            end
            OP_VEL2: begin
                r_nv2[i_cmd.idx] <= sat32(vsum);
            end
            OP_OUT: begin
                r_result.status <= i_cmd.status;
                for (int i = 0; i < 3; i++) begin
                    if (i_cmd.status == ST_RESOLVED) begin
                        r_result.pos1[i] <= r_np1[i];
                        r_result.vel1[i] <= r_nv1[i];
                        r_result.vel2[i] <= r_nv2[i];
                    end else begin
                        r_result.pos1[i] <= r_p1[i];
                        r_result.vel1[i] <= r_v1[i];
                        r_result.vel2[i] <= r_v2[i];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_flags.have_first = r_have_first;
        o_flags.zero       = zero;
        o_flags.far        = far;
        o_flags.sq_over    = r_sq > {2'b00, r_cc};
        o_flags.sqrt_last  = r_sb[0];
        o_flags.div_done   = div_done;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/spcr_ctrl.sv =====
// Sequencer for the collision core: walks the datapath through test, root,
// divisions and impulse. Depends on spcr_pkg.
`default_nettype none

module spcr_ctrl
    import spcr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire logic   i_command,
    input  wire t_flags i_flags,
    output logic        o_busy,
    output t_cmd        o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_idx, n_idx;
    t_job       r_job, n_job;
    t_status    r_status, n_status;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_job    = r_job;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_command && i_flags.have_first) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_flags.zero) begin
                    n_status = ST_COINCIDENT;
                    n_state  = S_OUT;
                end else if (i_flags.far) begin
                    n_status = ST_NO_CONTACT;
                    n_state  = S_OUT;
                end else begin
                    n_idx   = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (r_idx == LAST_AXIS) begin
                    n_idx   = '0;
                    n_state = S_CMP;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CMP: begin
                if (i_flags.sq_over) begin
                    n_status = ST_NO_CONTACT;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_flags.sqrt_last) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_job   = JOB_N0;
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_flags.div_done) begin
                    if (r_job == JOB_R2) begin
                        n_idx   = '0;
                        n_state = S_DOT;
                    end else begin
                        n_job   = t_job'(r_job + 3'd1);
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_DOT: begin
                if (r_idx == LAST_AXIS) begin
                    n_idx   = '0;
                    n_state = S_SCALE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SCALE: n_state = S_W1;
            S_W1:    n_state = S_W2;
            S_W2: begin
                n_idx   = '0;
                n_state = S_VEL1;
            end
            S_VEL1: begin
                if (r_idx == LAST_AXIS) begin
                    n_idx   = '0;
                    n_state = S_VEL2;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_VEL2: begin
                if (r_idx == LAST_AXIS) begin
                    n_idx    = '0;
                    n_status = ST_RESOLVED;
                    n_state  = S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.idx    = r_idx;
        o_cmd.job    = r_job;
        o_cmd.status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = i_command ? OP_CAPTURE : OP_LOAD;
                end else begin
                    o_cmd.op = OP_NONE;
                end
            end
            S_SQ:       o_cmd.op = OP_SQ;
            S_CMP:      o_cmd.op = OP_SQRT_INIT;
            S_SQRT:     o_cmd.op = OP_SQRT_STEP;
            S_PREP:     o_cmd.op = OP_PREP;
            S_DIV_GO:   o_cmd.op = OP_DIV_START;
            S_DIV_WAIT: o_cmd.op = i_flags.div_done ? OP_DIV_STORE : OP_NONE;
            S_DOT:      o_cmd.op = OP_DOT;
            S_SCALE:    o_cmd.op = OP_SCALE;
            S_W1:       o_cmd.op = OP_W1;
            S_W2:       o_cmd.op = OP_W2;
            S_VEL1:     o_cmd.op = OP_VEL1;
            S_VEL2:     o_cmd.op = OP_VEL2;
            S_OUT:      o_cmd.op = OP_OUT;
            default:    o_cmd.op = OP_NONE;
        endcase
        o_busy = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_job    <= JOB_N0;
            r_status <= ST_NO_CONTACT;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_job    <= n_job;
            r_status <= n_status;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sphere_pair_collision_resolve_core.sv =====
// Top level of the sphere pair collision core: ports, controller and datapath.
// Depends on spcr_pkg, spcr_ctrl, spcr_datapath (and spcr_div below it).
//
//   channel  | signals                          | transfer
//   ---------+----------------------------------+-----------------------------
//   body in  | start, busy, i_command, i_pos_*, | start high while busy low
//            | i_vel_*, i_mass                  |
//   result   | o_strobe, o_status, o_first_*,   | o_strobe high for one cycle
//            | o_second_*                       |
//   config   | i_cfg_we, i_cfg_data             | i_cfg_we high
//
// A load (command 0) stores the first body. A second body ends without the root and
// divisions when the centres coincide or are out of reach; a resolved contact runs
// the 31-step square root and eight divisions on the one shared divider. Reset is
// synchronous, active low, and leaves no first body stored. Results cannot be held
// off; the next body may start while a result is on the ports.
`default_nettype none

module sphere_pair_collision_resolve_core
    import spcr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic [31:0] i_pos_x,
    input  wire logic [31:0] i_pos_y,
    input  wire logic [31:0] i_pos_z,
    input  wire logic [31:0] i_vel_x,
    input  wire logic [31:0] i_vel_y,
    input  wire logic [31:0] i_vel_z,
    input  wire logic [31:0] i_mass,
    input  wire logic        i_cfg_we,
    input  wire logic [30:0] i_cfg_data,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic [31:0]      o_first_new_pos_x,
    output logic [31:0]      o_first_new_pos_y,
    output logic [31:0]      o_first_new_pos_z,
    output logic [31:0]      o_first_new_vel_x,
    output logic [31:0]      o_first_new_vel_y,
    output logic [31:0]      o_first_new_vel_z,
    output logic [31:0]      o_second_new_vel_x,
    output logic [31:0]      o_second_new_vel_y,
    output logic [31:0]      o_second_new_vel_z
);

    t_body   body;
    t_cmd    cmd;
    t_flags  flags;
    t_result result;
    logic    ctrl_busy;

    always_comb begin
        body.pos[0] = i_pos_x;
        body.pos[1] = i_pos_y;
        body.pos[2] = i_pos_z;
        body.vel[0] = i_vel_x;
        body.vel[1] = i_vel_y;
        body.vel[2] = i_vel_z;
        body.mass   = i_mass;
    end

    spcr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_flags   (flags),
        .o_busy    (ctrl_busy),
        .o_cmd     (cmd)
    );

    spcr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_body     (body),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_flags    (flags),
        .o_strobe   (o_strobe),
        .o_result   (result)
    );

    assign busy               = ctrl_busy;
    assign o_status           = result.status;
    assign o_first_new_pos_x  = result.pos1[0];
    assign o_first_new_pos_y  = result.pos1[1];
    assign o_first_new_pos_z  = result.pos1[2];
    assign o_first_new_vel_x  = result.vel1[0];
    assign o_first_new_vel_y  = result.vel1[1];
    assign o_first_new_vel_z  = result.vel1[2];
    assign o_second_new_vel_x = result.vel2[0];
    assign o_second_new_vel_y = result.vel2[1];
    assign o_second_new_vel_z = result.vel2[2];

endmodule

`default_nettype wire
